### sv/rgbe_rle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbe_rle_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIDTH_W = 13;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned PLANE_W = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd1024;
  localparam logic [15:0]        PLANAR_LIMIT     = 16'h7FFF;

  // plane codes
  localparam logic [PLANE_W-1:0] PLANE_PIXEL = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_CLAMP = 2'd1;
  localparam logic [STAT_W-1:0] ST_TRUNC = 2'd2;

  // byte codes of the stream
  localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'd2;
  localparam logic [BYTE_W-1:0] RUN_THRESH   = 8'd128;
  localparam logic [23:0]       REPEAT_MARK  = 24'h010101;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [INDEX_W-1:0] first_index;
    logic [WIDTH_W-1:0] run_count;
    logic [BYTE_W-1:0]  red_byte;
    logic [BYTE_W-1:0]  green_byte;
    logic [BYTE_W-1:0]  blue_byte;
    logic [BYTE_W-1:0]  exponent_byte;
    logic               line_done;
    logic [STAT_W-1:0]  status;
  } rec_t;

endpackage

`default_nettype wire

### sv/rgbe_rle_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbe_rle_in_stage (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire rgbe_rle_pkg::in_item_t in_item,
  input  wire                         consume,
  output logic                        item_valid,
  output rgbe_rle_pkg::in_item_t      item
);

  logic                   valid_r;
  logic                   valid_nxt;
  rgbe_rle_pkg::in_item_t item_r;
  logic                   accept;

  assign in_stall   = valid_r && !consume;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

### sv/rgbe_rle_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbe_rle_core #(
  parameter int unsigned MAX_LINE_WIDTH   = 4096,
  parameter int unsigned MIN_PLANAR_WIDTH = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_write_en,
  input  wire [12:0]                  cfg_line_width,
  input  wire                         fire,
  input  wire rgbe_rle_pkg::in_item_t item,
  output logic                        rec_valid,
  output rgbe_rle_pkg::rec_t          rec
);

  typedef enum logic [10:0] {
    PH_START  = 11'b000_0000_0001,
    PH_HDR_G  = 11'b000_0000_0010,
    PH_HDR_B  = 11'b000_0000_0100,
    PH_HDR_E  = 11'b000_0000_1000,
    PH_OLD0   = 11'b000_0001_0000,
    PH_OLD1   = 11'b000_0010_0000,
    PH_OLD2   = 11'b000_0100_0000,
    PH_OLD3   = 11'b000_1000_0000,
    PH_CODE   = 11'b001_0000_0000,
    PH_RUNVAL = 11'b010_0000_0000,
    PH_LIT    = 11'b100_0000_0000
  } phase_t;

  logic [12:0] line_width_r;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  plane_r, plane_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic        run_pend_r, run_pend_nxt;
  logic [1:0]  rshift_r, rshift_nxt;
  logic [31:0] last_pix_r, last_pix_nxt;
  logic [23:0] held_r, held_nxt;

  logic [12:0] width;
  logic [12:0] left;
  logic        planar_ok;
  logic [7:0]  b;
  logic [15:0] rep_cnt;
  logic        rep_over;
  logic [12:0] rep_n;

  logic        old_go;
  logic [12:0] old_n;
  logic [31:0] old_pix;
  logic [1:0]  old_status;
  logic        pr_go;
  logic [12:0] pr_n;
  logic [1:0]  pr_status;
  logic        line_clr;

  always_comb begin
    width = line_width_r;
    if (line_width_r == 13'd0) begin
      width = 13'd1;
    end else if ({3'b0, line_width_r} > 16'(MAX_LINE_WIDTH)) begin
      width = 13'(MAX_LINE_WIDTH);
    end
  end

  assign left      = width - pos_r;
  assign planar_ok = ({3'b0, width} >= 16'(MIN_PLANAR_WIDTH))
                  && ({3'b0, width} <= rgbe_rle_pkg::PLANAR_LIMIT);
  assign b         = item.byte_value;

  // repeat count is b << 8*shift; from shift 2 on any nonzero count overruns
  assign rep_cnt  = (rshift_r == 2'd0) ? {8'b0, b} : {b, 8'b0};
  assign rep_over = rshift_r[1] || (rep_cnt > {3'b0, left});
  assign rep_n    = rep_over ? left : rep_cnt[12:0];

  always_comb begin
    phase_nxt    = phase_r;
    plane_nxt    = plane_r;
    pos_nxt      = pos_r;
    pending_nxt  = pending_r;
    run_pend_nxt = run_pend_r;
    rshift_nxt   = rshift_r;
    last_pix_nxt = last_pix_r;
    held_nxt     = held_r;
    rec_valid    = 1'b0;
    rec          = '0;
    old_go       = 1'b0;
    old_n        = 13'd1;
    old_pix      = last_pix_r;
    old_status   = rgbe_rle_pkg::ST_OK;
    pr_go        = 1'b0;
    pr_n         = 13'd1;
    pr_status    = rgbe_rle_pkg::ST_OK;
    line_clr     = 1'b0;

    if (fire) begin
      if (item.end_of_input) begin
        if (phase_r != PH_START || pos_r != 13'd0 || plane_r != 2'd0) begin
          rec_valid       = 1'b1;
          rec.plane       = (phase_r == PH_CODE || phase_r == PH_RUNVAL || phase_r == PH_LIT)
                          ? {1'b0, plane_r} : rgbe_rle_pkg::PLANE_PIXEL;
          rec.first_index = pos_r[11:0];
          rec.run_count   = left;
          rec.line_done   = 1'b1;
          rec.status      = rgbe_rle_pkg::ST_TRUNC;
        end
        line_clr     = 1'b1;
        last_pix_nxt = '0;
      end else begin
        case (phase_r)
          PH_START: begin
            if (planar_ok && b == rgbe_rle_pkg::HDR_BYTE) begin
              phase_nxt = PH_HDR_G;
            end else begin
              held_nxt  = {16'b0, b};
              phase_nxt = PH_OLD1;
            end
          end
          PH_HDR_G: begin
            held_nxt  = {16'b0, b};
            phase_nxt = PH_HDR_B;
          end
          PH_HDR_B: begin
            held_nxt  = {held_r[23:16], b, held_r[7:0]};
            phase_nxt = PH_HDR_E;
          end
          PH_HDR_E: begin
            held_nxt = '0;
            if (held_r[7:0] != rgbe_rle_pkg::HDR_BYTE || held_r[15]) begin
              // not a planar header: the four bytes are an old-coded pixel
              old_pix      = {b, held_r[15:8], held_r[7:0], rgbe_rle_pkg::HDR_BYTE};
              last_pix_nxt = old_pix;
              rshift_nxt   = 2'd0;
              old_go       = 1'b1;
            end else begin
              plane_nxt = 2'd0;
              pos_nxt   = 13'd0;
              phase_nxt = PH_CODE;
            end
          end
          PH_OLD0: begin
            held_nxt  = {16'b0, b};
            phase_nxt = PH_OLD1;
          end
          PH_OLD1: begin
            held_nxt  = {held_r[23:16], b, held_r[7:0]};
            phase_nxt = PH_OLD2;
          end
          PH_OLD2: begin
            held_nxt  = {b, held_r[15:0]};
            phase_nxt = PH_OLD3;
          end
          PH_OLD3: begin
            held_nxt = '0;
            if (held_r == rgbe_rle_pkg::REPEAT_MARK) begin
              if (rshift_r != 2'd3) begin
                rshift_nxt = rshift_r + 2'd1;
              end
              if (b == 8'd0) begin
                phase_nxt = PH_OLD0;
              end else begin
                old_go     = 1'b1;
                old_n      = rep_n;
                old_status = rep_over ? rgbe_rle_pkg::ST_CLAMP : rgbe_rle_pkg::ST_OK;
              end
            end else begin
              old_pix      = {b, held_r};
              last_pix_nxt = old_pix;
              rshift_nxt   = 2'd0;
              old_go       = 1'b1;
            end
          end
          PH_CODE: begin
            if (b > rgbe_rle_pkg::RUN_THRESH) begin
              pending_nxt = {1'b0, b[6:0]};
              phase_nxt   = PH_RUNVAL;
            end else if (b != 8'd0) begin
              if ({5'b0, b} > left) begin
                pending_nxt  = left[7:0];
                run_pend_nxt = 1'b1;
              end else begin
                pending_nxt  = b;
                run_pend_nxt = 1'b0;
              end
              phase_nxt = PH_LIT;
            end
          end
          PH_RUNVAL: begin
            pr_go       = 1'b1;
            pr_n        = {5'b0, pending_r};
            if ({5'b0, pending_r} > left) begin
              pr_n      = left;
              pr_status = rgbe_rle_pkg::ST_CLAMP;
            end
            pending_nxt = 8'd0;
            phase_nxt   = PH_CODE;
          end
          PH_LIT: begin
            pr_go = 1'b1;
            if (pending_r <= 8'd1) begin
              pr_status    = run_pend_r ? rgbe_rle_pkg::ST_CLAMP : rgbe_rle_pkg::ST_OK;
              pending_nxt  = 8'd0;
              run_pend_nxt = 1'b0;
              phase_nxt    = PH_CODE;
            end else begin
              pending_nxt = pending_r - 8'd1;
            end
          end
          default: begin
            line_clr = 1'b1;
          end
        endcase
      end

      // whole-pixel record of the old coding
      if (old_go) begin
        rec_valid         = 1'b1;
        rec.plane         = rgbe_rle_pkg::PLANE_PIXEL;
        rec.first_index   = pos_r[11:0];
        rec.run_count     = old_n;
        rec.red_byte      = old_pix[7:0];
        rec.green_byte    = old_pix[15:8];
        rec.blue_byte     = old_pix[23:16];
        rec.exponent_byte = old_pix[31:24];
        rec.status        = old_status;
        if (old_n == left) begin
          rec.line_done = 1'b1;
          line_clr      = 1'b1;
        end else begin
          pos_nxt   = pos_r + old_n;
          phase_nxt = PH_OLD0;
        end
      end

      // single-plane record
      if (pr_go) begin
        rec_valid       = 1'b1;
        rec.plane       = {1'b0, plane_r};
        rec.first_index = pos_r[11:0];
        rec.run_count   = pr_n;
        rec.status      = pr_status;
        case (plane_r)
          2'd0:    rec.red_byte      = b;
          2'd1:    rec.green_byte    = b;
          2'd2:    rec.blue_byte     = b;
          default: rec.exponent_byte = b;
        endcase
        if (pr_n == left) begin
          if (plane_r == 2'd3) begin
            rec.line_done = 1'b1;
            line_clr      = 1'b1;
          end else begin
            plane_nxt = plane_r + 2'd1;
            pos_nxt   = 13'd0;
            phase_nxt = PH_CODE;
          end
        end else begin
          pos_nxt = pos_r + pr_n;
        end
      end
    end

    if (line_clr || cfg_write_en) begin
      phase_nxt    = PH_START;
      plane_nxt    = 2'd0;
      pos_nxt      = 13'd0;
      pending_nxt  = 8'd0;
      run_pend_nxt = 1'b0;
      rshift_nxt   = 2'd0;
      held_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= rgbe_rle_pkg::LINE_WIDTH_RESET;
      phase_r      <= PH_START;
      plane_r      <= 2'd0;
      pos_r        <= 13'd0;
      pending_r    <= 8'd0;
      run_pend_r   <= 1'b0;
      rshift_r     <= 2'd0;
      last_pix_r   <= '0;
      held_r       <= '0;
    end else begin
      if (cfg_write_en) begin
        line_width_r <= cfg_line_width;
      end
      phase_r    <= phase_nxt;
      plane_r    <= plane_nxt;
      pos_r      <= pos_nxt;
      pending_r  <= pending_nxt;
      run_pend_r <= run_pend_nxt;
      rshift_r   <= rshift_nxt;
      last_pix_r <= last_pix_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/rgbe_rle_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbe_rle_out_stage (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     load,
  input  wire rgbe_rle_pkg::rec_t rec_in,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire                     out_stall,
  output rgbe_rle_pkg::rec_t      rec_out
);

  logic               valid_r;
  logic               valid_nxt;
  rgbe_rle_pkg::rec_t rec_r;

  // register is free when empty or its beat leaves this cycle
  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign rec_out   = rec_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

endmodule

`default_nettype wire

### sv/rgbe_scanline_rle_decoder.sv
// RGBE scanline run-length decoder.
// Input channel: one byte of encoded pixel data per beat (in_byte_value), or an
// end-of-stream marker (in_end_of_input = 1). A beat is taken at a clock edge
// with in_valid high and in_stall low.
// Output channel: run records (plane, first_index, run_count, the four bytes,
// line_done, status), taken at an edge with out_valid high and out_stall low.
// Most bytes produce no record; a byte produces at most one.
// cfg_line_width sets pixels per scanline; a write also restarts line decoding.
// Write it only while no beat is in flight.
// Throughput: one byte per cycle while the receiver does not stall. A record's byte
// passes the input register, then is decoded into the output register.
// Each byte updates only the small line-state counters.
// When the receiver stalls, the held record stays put; one more byte can sit in
// the input register, after which in_stall rises until the record drains.
// Reset (rst_n low, synchronous) empties both registers, sets the line width to
// 1024 and returns the decoder to the start of a line with a zero last pixel.
`timescale 1ns / 1ps
`default_nettype none

module rgbe_scanline_rle_decoder #(
  parameter int unsigned MAX_LINE_WIDTH   = 4096,
  parameter int unsigned MIN_PLANAR_WIDTH = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_write_en,
  input  wire  [12:0] cfg_line_width,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_byte_value,
  input  wire         in_end_of_input,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_plane,
  output logic [11:0] out_first_index,
  output logic [12:0] out_run_count,
  output logic [7:0]  out_red_byte,
  output logic [7:0]  out_green_byte,
  output logic [7:0]  out_blue_byte,
  output logic [7:0]  out_exponent_byte,
  output logic        out_line_done,
  output logic [1:0]  out_status
);

  rgbe_rle_pkg::in_item_t in_item;
  rgbe_rle_pkg::in_item_t item;
  rgbe_rle_pkg::rec_t     rec;
  rgbe_rle_pkg::rec_t     rec_out;
  logic                   item_valid;
  logic                   can_load;
  logic                   fire;
  logic                   rec_valid;

  assign in_item.byte_value   = in_byte_value;
  assign in_item.end_of_input = in_end_of_input;
  assign fire                 = item_valid && can_load;

  rgbe_rle_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  rgbe_rle_core #(
    .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
    .MIN_PLANAR_WIDTH (MIN_PLANAR_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_line_width (cfg_line_width),
    .fire           (fire),
    .item           (item),
    .rec_valid      (rec_valid),
    .rec            (rec)
  );

  rgbe_rle_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && rec_valid),
    .rec_in    (rec),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rec_out   (rec_out)
  );

  assign out_plane         = rec_out.plane;
  assign out_first_index   = rec_out.first_index;
  assign out_run_count     = rec_out.run_count;
  assign out_red_byte      = rec_out.red_byte;
  assign out_green_byte    = rec_out.green_byte;
  assign out_blue_byte     = rec_out.blue_byte;
  assign out_exponent_byte = rec_out.exponent_byte;
  assign out_line_done     = rec_out.line_done;
  assign out_status        = rec_out.status;

endmodule

`default_nettype wire

### bench/rgbe_run_checker.sv
`timescale 1ns / 1ps

module rgbe_run_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_write_en,
  input  wire  [12:0] cfg_line_width,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [7:0]  in_byte_value,
  input  wire         in_end_of_input,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [2:0]  out_plane,
  input  wire  [11:0] out_first_index,
  input  wire  [12:0] out_run_count,
  input  wire  [7:0]  out_red_byte,
  input  wire  [7:0]  out_green_byte,
  input  wire  [7:0]  out_blue_byte,
  input  wire  [7:0]  out_exponent_byte,
  input  wire         out_line_done,
  input  wire  [1:0]  out_status,
  output int unsigned err_count,
  output int unsigned pending
);

  localparam int unsigned MAX_W      = 4096;
  localparam int unsigned PLANAR_MIN = 8;

  typedef enum logic [3:0] {
    PH_START, PH_HDR_G, PH_HDR_B, PH_HDR_E,
    PH_OLD0, PH_OLD1, PH_OLD2, PH_OLD3,
    PH_CODE, PH_RUNVAL, PH_LIT
  } dec_phase_t;

  // decoder state as the block should hold it
  logic [12:0]  line_w;
  dec_phase_t   phase;
  logic [1:0]   plane_idx;
  int unsigned  pos;
  int unsigned  lit_left;
  bit           lit_clamped;
  logic [1:0]   rep_shift;
  logic [31:0]  last_pix;
  logic [23:0]  held;

  rgbe_rle_pkg::rec_t expected_runs[$];
  int unsigned        n_err = 0;
  int unsigned        n_rec = 0;

  assign err_count = n_err;

  function automatic int unsigned eff_w();
    if (line_w == 13'd0) return 1;
    if (line_w > MAX_W) return MAX_W;
    return line_w;
  endfunction

  task automatic report(input string what);
    n_err++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report($sformatf("record %0d %s: got %0d, expected %0d", n_rec, name, got, want));
  endtask

  task automatic clear_line();
    phase       = PH_START;
    plane_idx   = 2'd0;
    pos         = 0;
    lit_left    = 0;
    lit_clamped = 1'b0;
    rep_shift   = 2'd0;
    held        = 24'd0;
  endtask

  task automatic push_run(input logic [2:0] plane, input int unsigned first,
                          input int unsigned count, input logic [31:0] pix,
                          input bit done, input logic [1:0] st);
    rgbe_rle_pkg::rec_t r;
    r.plane         = plane;
    r.first_index   = first[11:0];
    r.run_count     = count[12:0];
    r.red_byte      = pix[7:0];
    r.green_byte    = pix[15:8];
    r.blue_byte     = pix[23:16];
    r.exponent_byte = pix[31:24];
    r.line_done     = done;
    r.status        = st;
    expected_runs.push_back(r);
  endtask

  // whole-pixel run in the old coding, clamped at line end
  task automatic put_pixels(input longint unsigned count, input logic [31:0] pix);
    int unsigned w, left, n;
    logic [1:0]  st;
    w    = eff_w();
    left = w - pos;
    st   = rgbe_rle_pkg::ST_OK;
    if (count > longint'(left)) begin
      n  = left;
      st = rgbe_rle_pkg::ST_CLAMP;
    end else begin
      n = int'(count);
    end
    if (pos + n >= w) begin
      push_run(rgbe_rle_pkg::PLANE_PIXEL, pos, n, pix, 1'b1, st);
      clear_line();
    end else begin
      push_run(rgbe_rle_pkg::PLANE_PIXEL, pos, n, pix, 1'b0, st);
      pos  += n;
      phase = PH_OLD0;
    end
  endtask

  task automatic put_plane(input int unsigned n, input logic [7:0] val, input logic [1:0] st);
    int unsigned w;
    logic [1:0]  pl;
    logic [31:0] pix;
    w   = eff_w();
    pl  = plane_idx;
    pix = {24'd0, val} << (8 * pl);
    pos += n;
    if (pos >= w) begin
      if (pl == 2'd3) begin
        push_run({1'b0, pl}, pos - n, n, pix, 1'b1, st);
        clear_line();
      end else begin
        push_run({1'b0, pl}, pos - n, n, pix, 1'b0, st);
        plane_idx = pl + 2'd1;
        pos       = 0;
        phase     = PH_CODE;
      end
    end else begin
      push_run({1'b0, pl}, pos - n, n, pix, 1'b0, st);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    int unsigned      w, left, n;
    bit               planar;
    logic [7:0]       g, bl;
    logic [23:0]      h;
    logic [31:0]      pix;
    logic [1:0]       st;
    longint unsigned  count;
    w      = eff_w();
    planar = (w >= PLANAR_MIN);
    left   = w - pos;
    if (eoi) begin
      if (phase != PH_START || pos != 0 || plane_idx != 2'd0)
        push_run((phase >= PH_CODE) ? {1'b0, plane_idx} : rgbe_rle_pkg::PLANE_PIXEL,
                 pos, left, 32'd0, 1'b1, rgbe_rle_pkg::ST_TRUNC);
      clear_line();
      last_pix = 32'd0;
    end else begin
      case (phase)
        PH_START: begin
          if (planar && b == rgbe_rle_pkg::HDR_BYTE) begin
            phase = PH_HDR_G;
          end else begin
            held  = {16'd0, b};
            phase = PH_OLD1;
          end
        end
        PH_HDR_G: begin
          held  = {16'd0, b};
          phase = PH_HDR_B;
        end
        PH_HDR_B: begin
          held[15:8] = b;
          phase      = PH_HDR_E;
        end
        PH_HDR_E: begin
          g  = held[7:0];
          bl = held[15:8];
          held = 24'd0;
          if (g != rgbe_rle_pkg::HDR_BYTE || bl >= rgbe_rle_pkg::RUN_THRESH) begin
            // rejected header is pixel 0 of an old-coded line
            pix       = {b, bl, g, rgbe_rle_pkg::HDR_BYTE};
            last_pix  = pix;
            rep_shift = 2'd0;
            put_pixels(1, pix);
          end else begin
            plane_idx = 2'd0;
            pos       = 0;
            phase     = PH_CODE;
          end
        end
        PH_OLD0: begin
          held  = {16'd0, b};
          phase = PH_OLD1;
        end
        PH_OLD1: begin
          held[15:8] = b;
          phase      = PH_OLD2;
        end
        PH_OLD2: begin
          held[23:16] = b;
          phase       = PH_OLD3;
        end
        PH_OLD3: begin
          h    = held;
          held = 24'd0;
          if (h == rgbe_rle_pkg::REPEAT_MARK) begin
            count = longint'(b) << (8 * rep_shift);
            if (rep_shift != 2'd3) rep_shift++;
            if (count == 0) phase = PH_OLD0;
            else put_pixels(count, last_pix);
          end else begin
            last_pix  = {b, h};
            rep_shift = 2'd0;
            put_pixels(1, last_pix);
          end
        end
        PH_CODE: begin
          if (b > rgbe_rle_pkg::RUN_THRESH) begin
            lit_left = b[6:0];
            phase    = PH_RUNVAL;
          end else if (b != 8'd0) begin
            // literal longer than the plane: only the bytes that fit
            if (b > left) begin
              lit_left    = left;
              lit_clamped = 1'b1;
            end else begin
              lit_left    = b;
              lit_clamped = 1'b0;
            end
            phase = PH_LIT;
          end
        end
        PH_RUNVAL: begin
          n  = lit_left;
          st = rgbe_rle_pkg::ST_OK;
          if (n > left) begin
            n  = left;
            st = rgbe_rle_pkg::ST_CLAMP;
          end
          lit_left = 0;
          phase    = PH_CODE;
          put_plane(n, b, st);
        end
        PH_LIT: begin
          st = rgbe_rle_pkg::ST_OK;
          if (lit_left <= 1) begin
            st          = lit_clamped ? rgbe_rle_pkg::ST_CLAMP : rgbe_rle_pkg::ST_OK;
            lit_left    = 0;
            lit_clamped = 1'b0;
            phase       = PH_CODE;
          end else begin
            lit_left--;
          end
          put_plane(1, b, st);
        end
        default: clear_line();
      endcase
    end
  endtask

  task automatic compare_record();
    rgbe_rle_pkg::rec_t want;
    n_rec++;
    if (expected_runs.size() == 0) begin
      report($sformatf("record %0d arrived with nothing expected", n_rec));
    end else begin
      want = expected_runs.pop_front();
      check_field("plane", out_plane, want.plane);
      check_field("first_index", out_first_index, want.first_index);
      check_field("run_count", out_run_count, want.run_count);
      check_field("red_byte", out_red_byte, want.red_byte);
      check_field("green_byte", out_green_byte, want.green_byte);
      check_field("blue_byte", out_blue_byte, want.blue_byte);
      check_field("exponent_byte", out_exponent_byte, want.exponent_byte);
      check_field("line_done", out_line_done, want.line_done);
      check_field("status", out_status, want.status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_w   = rgbe_rle_pkg::LINE_WIDTH_RESET;
      last_pix = 32'd0;
      clear_line();
      expected_runs.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) compare_record();
      if (cfg_write_en) begin
        line_w = cfg_line_width;
        clear_line();
      end
      if (in_valid && !in_stall) decode_byte(in_byte_value, in_end_of_input);
      pending <= expected_runs.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_BEATS = 1000;
  localparam int unsigned MAX_W        = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [12:0] cfg_line_width = 13'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte_value = 8'd0;
  logic        in_end_of_input = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [2:0]  out_plane;
  wire  [11:0] out_first_index;
  wire  [12:0] out_run_count;
  wire  [7:0]  out_red_byte;
  wire  [7:0]  out_green_byte;
  wire  [7:0]  out_blue_byte;
  wire  [7:0]  out_exponent_byte;
  wire         out_line_done;
  wire  [1:0]  out_status;

  int unsigned err_count;
  int unsigned pending;
  int unsigned beats_sent = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;

  always #6 clk = ~clk;

  rgbe_scanline_rle_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_line_width   (cfg_line_width),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane        (out_plane),
    .out_first_index  (out_first_index),
    .out_run_count    (out_run_count),
    .out_red_byte     (out_red_byte),
    .out_green_byte   (out_green_byte),
    .out_blue_byte    (out_blue_byte),
    .out_exponent_byte(out_exponent_byte),
    .out_line_done    (out_line_done),
    .out_status       (out_status)
  );

  rgbe_run_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_line_width   (cfg_line_width),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_end_of_input  (in_end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane        (out_plane),
    .out_first_index  (out_first_index),
    .out_run_count    (out_run_count),
    .out_red_byte     (out_red_byte),
    .out_green_byte   (out_green_byte),
    .out_blue_byte    (out_blue_byte),
    .out_exponent_byte(out_exponent_byte),
    .out_line_done    (out_line_done),
    .out_status       (out_status),
    .err_count        (err_count),
    .pending          (pending)
  );

  // mostly zero, sometimes short, rarely long
  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned min_u(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned eff_width(input int unsigned w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_delay();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(input logic [7:0] b, input bit eoi);
    int unsigned gap;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_byte_value   <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    gap = calm ? 0 : pick_delay();
    if (gap != 0) begin
      @(negedge clk);
      in_valid        <= 1'b0;
      in_byte_value   <= 8'($urandom);
      in_end_of_input <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send4(input logic [7:0] a, input logic [7:0] b,
                       input logic [7:0] c, input logic [7:0] d);
    send(a, 1'b0);
    send(b, 1'b0);
    send(c, 1'b0);
    send(d, 1'b0);
  endtask

  // hold off until every expected record is out, plus the pipeline depth
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_width(input logic [12:0] w);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_line_width <= w;
    calm           <= ($urandom_range(0, 3) == 0);
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic send_planar_line(input int unsigned w);
    int unsigned pl, pos, left, cnt, code;
    send4(rgbe_rle_pkg::HDR_BYTE, rgbe_rle_pkg::HDR_BYTE, 8'($urandom_range(0, 127)),
          8'($urandom));
    for (pl = 0; pl < 4; pl++) begin
      pos = 0;
      while (pos < w) begin
        left = w - pos;
        if ($urandom_range(0, 59) == 0) begin
          send(8'd0, 1'b1);
          return;
        end
        if ($urandom_range(0, 19) == 0) begin
          send(8'd0, 1'b0);
        end else if ((w > 256) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) == 0)) begin
          if (w > 256) cnt = $urandom_range(96, 127);
          else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, 127);
          else cnt = $urandom_range(1, min_u(left, 127));
          code = rgbe_rle_pkg::RUN_THRESH + cnt;
          send(8'(code), 1'b0);
          send(8'($urandom), 1'b0);
          pos += min_u(cnt, left);
        end else begin
          if (w > 256) code = $urandom_range(1, 8);
          else if ($urandom_range(0, 4) == 0) code = $urandom_range(1, 128);
          else code = $urandom_range(1, min_u(left, 128));
          cnt = min_u(code, left);
          send(8'(code), 1'b0);
          repeat (cnt) send(8'($urandom), 1'b0);
          pos += cnt;
        end
      end
    end
  endtask

  task automatic send_old_line(input int unsigned w);
    int unsigned     pos, shift, n;
    longint unsigned cnt;
    logic [7:0]      r, g, bl;
    pos   = 0;
    shift = 0;
    while (pos < w) begin
      if ($urandom_range(0, 39) == 0) begin
        send(8'd0, 1'b1);
        return;
      end
      if ($urandom_range(0, 9) < ((w > 256) ? 9 : 3)) begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          1, 2:    n = $urandom_range(1, 255);
          default: n = $urandom_range(1, min_u(w - pos, 255));
        endcase
        send4(8'd1, 8'd1, 8'd1, 8'(n));
        cnt = longint'(n) << (8 * shift);
        if (shift < 3) shift++;
        if (cnt >= longint'(w - pos)) pos = w;
        else pos = pos + int'(cnt);
      end else begin
        r  = 8'($urandom);
        g  = 8'($urandom);
        bl = 8'($urandom);
        if (pos == 0 && $urandom_range(0, 7) == 0) r = rgbe_rle_pkg::HDR_BYTE;
        if ({bl, g, r} == rgbe_rle_pkg::REPEAT_MARK) bl = 8'd0;
        // keep a line-start pixel from opening a planar line
        if (pos == 0 && w >= 8 && r == rgbe_rle_pkg::HDR_BYTE
            && g == rgbe_rle_pkg::HDR_BYTE) bl[7] = 1'b1;
        send4(r, g, bl, 8'($urandom));
        shift = 0;
        pos++;
      end
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 24)) send(8'($urandom), ($urandom_range(0, 29) == 0));
    send(8'($urandom), 1'b1);
  endtask

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [12:0] w;
    int unsigned ew, lines, target;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // repeat before any pixel copies the zeroed last pixel; a zero count still
    // bumps the shift, so the next repeat overruns the line and is clamped
    send4(8'd1, 8'd1, 8'd1, 8'd3);
    send4(8'd1, 8'd1, 8'd1, 8'd0);
    send4(8'd1, 8'd1, 8'd1, 8'd255);
    send(8'd0, 1'b1);

    set_width(13'd8);
    send4(rgbe_rle_pkg::HDR_BYTE, rgbe_rle_pkg::HDR_BYTE, 8'd127, 8'd0);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    send(8'd0, 1'b0);
    send(8'd134, 1'b0);
    send(8'd17, 1'b0);
    send(8'd5, 1'b0);
    send(8'd128, 1'b0);
    send(8'd127, 1'b0);
    send(8'd0, 1'b1);
    // B of 128 rejects the header, then the line is cut short
    send4(rgbe_rle_pkg::HDR_BYTE, rgbe_rle_pkg::HDR_BYTE, 8'd128, 8'd1);
    send(8'd0, 1'b1);

    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      case ($urandom_range(0, 19))
        0:       w = 13'd0;
        1:       w = 13'd1;
        2:       w = 13'd7;
        3:       w = 13'd8;
        4:       w = 13'd4096;
        5:       w = 13'd8191;
        6:       w = 13'($urandom_range(0, 8191));
        default: w = 13'($urandom_range(2, 40));
      endcase
      set_width(w);
      ew    = eff_width(w);
      lines = (ew > 256) ? 1 : $urandom_range(2, 8);
      repeat (lines) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: if (ew >= 8) send_planar_line(ew); else send_old_line(ew);
          6, 7, 8:          send_old_line(ew);
          default:          send_noise();
        endcase
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    calm     <= 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
